@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

  // Queue geometry
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 8;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - OCC_W;

  // Command codes carried on in_tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // Operation issued by the controller to the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_UNDERFLOW,
    OP_OVERFLOW
  } op_t;

  // Controller states
  typedef enum logic {
    FSM_IDLE,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_cmd,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  fsm_t state_r;
  fsm_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          state_nxt = FSM_OUT;
        end
      end
      FSM_OUT: begin
        if (out_tready) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Outputs: handshakes and the operation for the datapath
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    dp_cmd.op  = OP_NONE;
    unique case (state_r)
      FSM_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_cmd == CMD_INSERT) begin
            dp_cmd.op = dp_stat.full ? OP_OVERFLOW : OP_INSERT;
          end else begin
            dp_cmd.op = dp_stat.empty ? OP_UNDERFLOW : OP_REMOVE;
          end
        end
      end
      FSM_OUT: begin
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/spq_datapath.sv @@
module spq_datapath
  import spq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                dp_cmd,
  output dp_stat_t               dp_stat,
  input  logic [VALUE_W-1:0]     in_value,
  input  logic [PRIO_W-1:0]      in_priority,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  logic [VALUE_W-1:0] slot_value_r   [CAPACITY];
  logic [VALUE_W-1:0] slot_value_nxt [CAPACITY];
  logic [PRIO_W-1:0]  slot_prio_r    [CAPACITY];
  logic [PRIO_W-1:0]  slot_prio_nxt  [CAPACITY];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [VALUE_W-1:0] res_value_r;
  logic [VALUE_W-1:0] res_value_nxt;
  status_t            res_status_r;
  status_t            res_status_nxt;

  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] prev_gt;
  logic [CAPACITY-1:0] ins_here;

  // Queue status for the controller
  assign dp_stat.full  = (count_r == CNT_W'(CAPACITY));
  assign dp_stat.empty = (count_r == '0);

  // Per-cell compare: a held entry with a larger priority number moves back
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (slot_prio_r[i] > in_priority);
    end
    prev_gt[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      prev_gt[i] = gt[i-1];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      ins_here[i] = !prev_gt[i] && (gt[i] || (CNT_W'(i) == count_r));
    end
  end

  // Cell update: shift back on insert, shift forward on remove
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_value_nxt[i] = slot_value_r[i];
      slot_prio_nxt[i]  = slot_prio_r[i];
      if (dp_cmd.op == OP_INSERT) begin
        if (prev_gt[i]) begin
          if (i > 0) begin
            slot_value_nxt[i] = slot_value_r[i-1];
            slot_prio_nxt[i]  = slot_prio_r[i-1];
          end
        end else if (ins_here[i]) begin
          slot_value_nxt[i] = in_value;
          slot_prio_nxt[i]  = in_priority;
        end
      end else if (dp_cmd.op == OP_REMOVE) begin
        if (i < CAPACITY - 1) begin
          slot_value_nxt[i] = slot_value_r[i+1];
          slot_prio_nxt[i]  = slot_prio_r[i+1];
        end
      end
    end
  end

  // Count and result
  always_comb begin
    count_nxt      = count_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    case (dp_cmd.op)
      OP_INSERT: begin
        count_nxt      = count_r + CNT_W'(1);
        res_value_nxt  = '0;
        res_status_nxt = ST_INSERTED;
      end
      OP_REMOVE: begin
        count_nxt      = count_r - CNT_W'(1);
        res_value_nxt  = slot_value_r[0];
        res_status_nxt = ST_REMOVED;
      end
      OP_UNDERFLOW: begin
        res_value_nxt  = '0;
        res_status_nxt = ST_UNDERFLOW;
      end
      OP_OVERFLOW: begin
        res_value_nxt  = '0;
        res_status_nxt = ST_OVERFLOW;
      end
      default: begin
        res_value_nxt = res_value_r;
      end
    endcase
  end

  // Entry cells and result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_value_r[i] <= slot_value_nxt[i];
      slot_prio_r[i]  <= slot_prio_nxt[i];
    end
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, OCC_W'(count_r), res_value_r};
  assign out_tuser = res_status_r;

endmodule

@@ hw/rtl/stable_priority_queue_unit.sv @@
// Channel | tdata (low bit up)                          | tuser
// in_     | in_value[31:0], in_priority[39:32]          | cmd[0]
// out_    | out_value[31:0], occupancy[36:32], zero pad | status[1:0]
//
// In the accept cycle all entry cells are compared in parallel and updated,
// then the result register presents the beat.
// A new input beat is taken once the previous result beat has been taken.
// A stalled result holds in the output register until out_tready.
// Reset (rst_n low, synchronous) empties the queue; entry cells keep data.
module stable_priority_queue_unit
  import spq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // in_value[31:0], in_priority[39:32]
  input  logic [0:0]             in_tuser,   // cmd[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_value[31:0], occupancy[36:32], pad
  output logic [1:0]             out_tuser   // status[1:0]
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_stat    (dp_stat),
    .dp_cmd     (dp_cmd)
  );

  spq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .in_value    (in_tdata[VALUE_W-1:0]),
    .in_priority (in_tdata[VALUE_W+PRIO_W-1:VALUE_W]),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

@@ sim/stable_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  // One result beat as the checker sees it
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [OCC_W-1:0]   occ;
  } pq_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // in_value[31:0], in_priority[39:32]
  logic [0:0]             in_tuser   = CMD_INSERT;  // cmd[0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // out_value[31:0], occupancy[36:32], pad
  logic [1:0]             out_tuser;         // status[1:0]

  // Shadow copy of the queue contents, front entry at index 0
  logic [VALUE_W-1:0] shadow_value [CAPACITY];
  logic [PRIO_W-1:0]  shadow_prio  [CAPACITY];
  int                 shadow_count = 0;
  pq_result_t         pending_results [$];

  bit          pace_in  = 1'b1;
  bit          pace_out = 1'b1;
  int unsigned err_cnt  = 0;
  int unsigned beats_in = 0;
  int unsigned n_status [4];
  int unsigned stall_left = 0;

  stable_priority_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one operation to the shadow queue and return the result it owes
  function automatic pq_result_t predict_queue_op(logic cmd, logic [VALUE_W-1:0] value,
                                                  logic [PRIO_W-1:0] prio);
    pq_result_t res;
    int         pos;
    res.value = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_OVERFLOW;
      end else begin
        // land behind every entry of equal or better priority
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = value;
        shadow_prio[pos]  = prio;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_UNDERFLOW;
    end else begin
      res.value = shadow_value[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_value[i-1] = shadow_value[i];
        shadow_prio[i-1]  = shadow_prio[i];
      end
      shadow_count--;
      res.status = ST_REMOVED;
    end
    res.occ = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  // Predict on each input beat, then compare each result beat with the oldest prediction
  always @(posedge clk) begin
    pq_result_t             want;
    logic [VALUE_W-1:0]     got_value;
    logic [OCC_W-1:0]       got_occ;
    logic [OUT_PAD_W-1:0]   got_pad;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_queue_op(in_tuser[0], in_tdata[VALUE_W-1:0],
                                                   in_tdata[VALUE_W +: PRIO_W]));
        beats_in++;
      end
      if (out_tvalid && out_tready) begin
        got_value = out_tdata[VALUE_W-1:0];
        got_occ   = out_tdata[VALUE_W +: OCC_W];
        got_pad   = out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W];
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing pending: value %h status %0d occ %0d",
                   $time, got_value, out_tuser, got_occ);
        end else begin
          want = pending_results.pop_front();
          n_status[want.status]++;
          if (got_value !== want.value) begin
            err_cnt++;
            $display("%0t: out_value mismatch, expected %h, actual %h",
                     $time, want.value, got_value);
          end
          if (out_tuser !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_tuser);
          end
          if (got_occ !== want.occ) begin
            err_cnt++;
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occ, got_occ);
          end
          if (got_pad !== '0) begin
            err_cnt++;
            $display("%0t: tdata pad mismatch, expected %h, actual %h",
                     $time, {OUT_PAD_W{1'b0}}, got_pad);
          end
        end
      end
    end
  end

  // Receiver: after each taken beat, hold off tready for a random stretch when pace_out is set
  always @(posedge clk) begin
    int unsigned draw;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      draw = pace_out ? $urandom_range(0, 7) : 0;
      stall_left <= draw;
      out_tready <= (draw == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Send one beat, after a random gap when pace_in is set; tvalid stays high into the next call
  task automatic issue_op(input logic cmd, input logic [VALUE_W-1:0] value,
                          input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = pace_in ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, value};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop tvalid and hold until every predicted result has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Favor narrow ranges so that equal priorities are common
  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 3))
      0:       return PRIO_W'($urandom_range(0, 3));
      1:       return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      2:       return PRIO_W'($urandom_range(252, 255));
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  // Underflow on empty, fill with extremes and ties, overflow, then pop a few
  task automatic test_directed();
    logic [VALUE_W-1:0] extreme_vals [4] = '{32'h8000_0000, 32'h7fff_ffff,
                                             32'h0000_0000, 32'hffff_ffff};
    logic [PRIO_W-1:0]  extreme_prios [4] = '{8'd255, 8'd0, 8'd255, 8'd0};
    pace_in  = 1'b1;
    pace_out = 1'b1;
    issue_op(CMD_REMOVE, $urandom, PRIO_W'($urandom));
    for (int i = 0; i < CAPACITY; i++) begin
      if (i < 4) issue_op(CMD_INSERT, extreme_vals[i], extreme_prios[i]);
      else       issue_op(CMD_INSERT, $urandom, (i % 2 != 0) ? 8'd7 : 8'($urandom));
    end
    issue_op(CMD_INSERT, $urandom, 8'd0);
    repeat (6) issue_op(CMD_REMOVE, $urandom, PRIO_W'($urandom));
  endtask

  // Let the queue go quiet, then run back to back with no stalls on either side
  task automatic test_drain_then_burst();
    wait_results_drained();
    pace_in  = 1'b0;
    pace_out = 1'b0;
    repeat (20) begin
      issue_op(($urandom_range(0, 2) != 0) ? CMD_INSERT : CMD_REMOVE, pick_value(), pick_prio());
    end
  endtask

  // Blocks of 50 beats, each biased toward filling, draining or neither
  task automatic test_random(input int unsigned n_blocks);
    int unsigned ins_weight;
    logic        cmd;
    for (int b = 0; b < n_blocks; b++) begin
      pace_in  = ($urandom_range(0, 3) != 0);
      pace_out = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       ins_weight = 85;
        1:       ins_weight = 15;
        default: ins_weight = 50;
      endcase
      repeat (50) begin
        cmd = ($urandom_range(0, 99) < ins_weight) ? CMD_INSERT : CMD_REMOVE;
        issue_op(cmd, pick_value(), pick_prio());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_drain_then_burst();
    test_random(24);
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d beats: %0d inserts, %0d removes, %0d underflows, %0d overflows",
             beats_in, n_status[ST_INSERTED], n_status[ST_REMOVED],
             n_status[ST_UNDERFLOW], n_status[ST_OVERFLOW]);
    $display("Exercised priority ties, both queue limits and random stalls on both sides");
    if (err_cnt == 0) begin
      $display("stable_priority_queue_unit regression: pass");
    end else begin
      $display("stable_priority_queue_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("stable_priority_queue_unit regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/stable_priority_queue_unit.sv
sim/stable_priority_queue_unit_tb.sv
